// ===== hw/rtl/e8alu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// e8alu_pkg
// Shared types and constants for the eight-bit ALU with decimal mode:
// operation codes, status bit positions and the adder result bundle.
// ----------------------------------------------------------------------------
package e8alu_pkg;

   localparam int DataWidth = 8;
   localparam int OpWidth   = 4;

   typedef logic [DataWidth-1:0] byte_type;
   typedef logic [OpWidth-1:0]   op_type;

   // Operation codes.
   localparam op_type OP_OR   = 4'd0;
   localparam op_type OP_AND  = 4'd1;
   localparam op_type OP_XOR  = 4'd2;
   localparam op_type OP_ADD  = 4'd3;
   localparam op_type OP_SUB  = 4'd4;
   localparam op_type OP_CMP  = 4'd5;
   localparam op_type OP_ASL  = 4'd6;
   localparam op_type OP_ROL  = 4'd7;
   localparam op_type OP_LSR  = 4'd8;
   localparam op_type OP_ROR  = 4'd9;
   localparam op_type OP_INC  = 4'd10;
   localparam op_type OP_DEC  = 4'd11;
   localparam op_type OP_BIT  = 4'd12;
   localparam op_type OP_LOAD = 4'd13;

   // Status byte bit positions.
   localparam int FlagC = 0;
   localparam int FlagZ = 1;
   localparam int FlagD = 3;
   localparam int FlagV = 6;
   localparam int FlagN = 7;

   // Decimal adjust constants.
   localparam logic [4:0] NibbleAdjust = 5'h06;
   localparam logic [4:0] NibbleLimit  = 5'h0A;
   localparam logic [9:0] ByteAdjust   = 10'h060;
   localparam logic [9:0] ByteLimit    = 10'h0A0;
   localparam logic [5:0] BorrowFix    = 6'd26;

   // Result byte and the four arithmetic flags from the adder unit.
   typedef struct packed {
      byte_type result;
      logic     c;
      logic     z;
      logic     v;
      logic     n;
   } arith_type;

endpackage : e8alu_pkg
`default_nettype wire

// ===== hw/rtl/eight_bit_cpu_alu_with_decimal_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eight_bit_cpu_alu_with_decimal_unit
// Eight-bit CPU ALU with binary and decimal add and subtract, logic,
// compare, shift, rotate, increment, decrement, bit test and load.
// ----------------------------------------------------------------------------
// Each request carries an operation, the register value, the operand byte
// and the status byte, and produces exactly one response with the result
// byte and the updated status byte. A request is latched into an input
// register at the edge that takes it, evaluated by the combinational ALU
// while it is held there and captured in the response register when that
// register may load, so the response is presented from a register. The
// block sustains one request per clock while rsp_stall is low: both
// registers advance together, and the input register keeps taking
// requests while a finished response waits, until both stages are full
// and rsp_stall is high. The cycle time is set by the decimal adder path
// (low digit add, digit adjust, high digit add and byte adjust). There is
// no configuration and no internal state beyond the two pipeline
// registers.
// ----------------------------------------------------------------------------
module eight_bit_cpu_alu_with_decimal_unit (
   input  wire                       clock,
   input  wire                       reset,
   // Request channel.
   input  wire                       req_valid,
   output logic                      req_stall,
   input  wire e8alu_pkg::op_type    req_operation,
   input  wire e8alu_pkg::byte_type  req_reg_value,
   input  wire e8alu_pkg::byte_type  req_operand,
   input  wire e8alu_pkg::byte_type  req_status_in,
   // Response channel.
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output e8alu_pkg::byte_type       rsp_result,
   output e8alu_pkg::byte_type       rsp_status_out
);
   import e8alu_pkg::*;

   // Input stage.
   logic     in_valid_ff;
   logic     in_valid_in;
   op_type   in_operation_ff;
   byte_type in_reg_value_ff;
   byte_type in_operand_ff;
   byte_type in_status_ff;

   // Response stage.
   logic     out_valid_ff;
   logic     out_valid_in;
   byte_type out_result_ff;
   byte_type out_status_ff;

   // ALU outputs for the request in the input stage.
   byte_type alu_result;
   byte_type alu_status;

   logic     out_load;
   logic     in_load;

   // The response register may load when it is empty or being drained.
   // The input register may load when it is empty or moving forward, so
   // a new request is taken while a response is still waiting.
   assign out_load     = ~out_valid_ff | ~rsp_stall;
   assign in_load      = ~in_valid_ff | out_load;
   assign req_stall    = ~in_load;

   assign in_valid_in  = in_load  ? req_valid   : in_valid_ff;
   assign out_valid_in = out_load ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers only change when their stage takes a new request.
   always_ff @(posedge clock) begin
      if (in_load && req_valid) begin
         in_operation_ff <= req_operation;
         in_reg_value_ff <= req_reg_value;
         in_operand_ff   <= req_operand;
         in_status_ff    <= req_status_in;
      end
      if (out_load && in_valid_ff) begin
         out_result_ff <= alu_result;
         out_status_ff <= alu_status;
      end
   end

   e8alu_core u_core (
      .operation  (in_operation_ff),
      .reg_value  (in_reg_value_ff),
      .operand    (in_operand_ff),
      .status_in  (in_status_ff),
      .result     (alu_result),
      .status_out (alu_status)
   );

   assign rsp_valid      = out_valid_ff;
   assign rsp_result     = out_result_ff;
   assign rsp_status_out = out_status_ff;

endmodule : eight_bit_cpu_alu_with_decimal_unit
`default_nettype wire

// ===== hw/rtl/e8alu_addsub.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// e8alu_addsub
// Add with carry and subtract with borrow, binary or decimal, with the
// flag behavior of the original NMOS part.
// ----------------------------------------------------------------------------
module e8alu_addsub (
   input  wire e8alu_pkg::byte_type  a,
   input  wire e8alu_pkg::byte_type  m,
   input  wire logic                 cin,
   input  wire logic                 dec,
   output e8alu_pkg::arith_type      add_out,
   output e8alu_pkg::arith_type      sub_out
);
   import e8alu_pkg::*;

   // Addition.
   logic [4:0] add_lo;
   logic [3:0] add_lo_nib;
   logic       add_lo_carry;
   logic [4:0] add_hi;
   logic [9:0] add_sum;
   logic [9:0] add_adj;
   logic [7:0] add_bin;

   // Subtraction.
   logic signed [5:0]  sub_lo;
   logic        [5:0]  sub_lo_fix;
   logic signed [5:0]  sub_lo_adj;
   logic signed [10:0] sub_d;
   logic signed [10:0] sub_d_adj;
   logic        [8:0]  sub_bin;

   always_comb begin
      add_lo = {1'b0, a[3:0]} + {1'b0, m[3:0]} + {4'd0, cin};
      if (dec && (add_lo >= NibbleLimit)) begin
         add_lo_nib   = 4'(add_lo + NibbleAdjust);
         add_lo_carry = 1'b1;
      end else begin
         add_lo_nib   = add_lo[3:0];
         add_lo_carry = add_lo[4];
      end
      add_hi  = {1'b0, a[7:4]} + {1'b0, m[7:4]} + {4'd0, add_lo_carry};
      add_sum = {1'b0, add_hi, add_lo_nib};
      // N and V come from the partly adjusted sum.
      add_adj = (dec && (add_sum >= ByteLimit)) ? add_sum + ByteAdjust : add_sum;
      add_bin = a + m + {7'd0, cin};

      add_out.result = add_adj[7:0];
      add_out.n      = add_sum[7];
      add_out.v      = ~(a[7] ^ m[7]) & (a[7] ^ add_sum[7]);
      add_out.c      = (add_adj[9:8] != 2'b00);
      add_out.z      = (add_bin == 8'd0);
   end

   always_comb begin
      sub_lo     = $signed({2'b00, a[3:0]}) - $signed({2'b00, m[3:0]})
                   + $signed({5'd0, cin}) - 6'sd1;
      sub_lo_fix = 6'(sub_lo) + BorrowFix;
      // A negative low digit wraps to -16..-1 after the decimal fix.
      sub_lo_adj = (dec && sub_lo[5]) ? $signed({2'b11, sub_lo_fix[3:0]}) : sub_lo;
      sub_d      = 11'(sub_lo_adj) + $signed({3'b000, a[7:4], 4'h0})
                   - $signed({3'b000, m[7:4], 4'h0});
      sub_d_adj  = (dec && sub_d[10]) ? sub_d - $signed({1'b0, ByteAdjust}) : sub_d;
      sub_bin    = {1'b0, a} + {1'b0, ~m} + {8'd0, cin};

      // All subtract flags follow the binary difference.
      sub_out.result = sub_d_adj[7:0];
      sub_out.n      = sub_bin[7];
      sub_out.v      = (a[7] ^ m[7]) & (a[7] ^ sub_bin[7]);
      sub_out.c      = sub_bin[8];
      sub_out.z      = (sub_bin[7:0] == 8'd0);
   end

endmodule : e8alu_addsub
`default_nettype wire

// ===== hw/rtl/e8alu_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// e8alu_core
// Combinational ALU: operation select, logic, shifts, increment and
// decrement, compare, bit test and status byte update.
// ----------------------------------------------------------------------------
module e8alu_core (
   input  wire e8alu_pkg::op_type    operation,
   input  wire e8alu_pkg::byte_type  reg_value,
   input  wire e8alu_pkg::byte_type  operand,
   input  wire e8alu_pkg::byte_type  status_in,
   output e8alu_pkg::byte_type       result,
   output e8alu_pkg::byte_type       status_out
);
   import e8alu_pkg::*;

   arith_type  add_out;
   arith_type  sub_out;
   logic [8:0] cmp_diff;
   logic       cin;

   function automatic byte_type set_nz(byte_type st, byte_type r);
      byte_type s;
      s        = st;
      s[FlagN] = r[7];
      s[FlagZ] = (r == 8'd0);
      return s;
   endfunction

   assign cin      = status_in[FlagC];
   assign cmp_diff = {1'b0, reg_value} - {1'b0, operand};

   e8alu_addsub u_addsub (
      .a       (reg_value),
      .m       (operand),
      .cin     (cin),
      .dec     (status_in[FlagD]),
      .add_out (add_out),
      .sub_out (sub_out)
   );

   always_comb begin
      result     = reg_value;
      status_out = status_in;
      case (operation)
         OP_OR: begin
            result     = reg_value | operand;
            status_out = set_nz(status_in, result);
         end
         OP_AND: begin
            result     = reg_value & operand;
            status_out = set_nz(status_in, result);
         end
         OP_XOR: begin
            result     = reg_value ^ operand;
            status_out = set_nz(status_in, result);
         end
         OP_ADD: begin
            result            = add_out.result;
            status_out[FlagC] = add_out.c;
            status_out[FlagZ] = add_out.z;
            status_out[FlagV] = add_out.v;
            status_out[FlagN] = add_out.n;
         end
         OP_SUB: begin
            result            = sub_out.result;
            status_out[FlagC] = sub_out.c;
            status_out[FlagZ] = sub_out.z;
            status_out[FlagV] = sub_out.v;
            status_out[FlagN] = sub_out.n;
         end
         OP_CMP: begin
            status_out[FlagC] = ~cmp_diff[8];
            status_out[FlagZ] = (reg_value == operand);
            status_out[FlagN] = cmp_diff[7];
         end
         OP_ASL: begin
            result            = {operand[6:0], 1'b0};
            status_out[FlagC] = operand[7];
            status_out        = set_nz(status_out, result);
         end
         OP_ROL: begin
            result            = {operand[6:0], cin};
            status_out[FlagC] = operand[7];
            status_out        = set_nz(status_out, result);
         end
         OP_LSR: begin
            result            = {1'b0, operand[7:1]};
            status_out[FlagC] = operand[0];
            status_out        = set_nz(status_out, result);
         end
         OP_ROR: begin
            result            = {cin, operand[7:1]};
            status_out[FlagC] = operand[0];
            status_out        = set_nz(status_out, result);
         end
         OP_INC: begin
            result     = operand + 8'd1;
            status_out = set_nz(status_in, result);
         end
         OP_DEC: begin
            result     = operand - 8'd1;
            status_out = set_nz(status_in, result);
         end
         OP_BIT: begin
            status_out[FlagN] = operand[7];
            status_out[FlagV] = operand[6];
            status_out[FlagZ] = ((reg_value & operand) == 8'd0);
         end
         OP_LOAD: begin
            result     = operand;
            status_out = set_nz(status_in, result);
         end
         default: begin
            // Unused codes pass the register value and status through.
            result     = reg_value;
            status_out = status_in;
         end
      endcase
   end

endmodule : e8alu_core
`default_nettype wire
